/* rtl/assert_macros.svh */
// assertion macros shared by the predictor rtl
// each macro takes a label, a property expression and a message string
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/gbp_pkg.sv */
// types and constants for the gshare branch predictor
// no dependencies
`default_nettype none

package gbp_pkg;

  // 2-bit saturating counter
  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MIN   = 2'd0;
  localparam ctr_t CTR_MAX   = 2'd3;
  localparam ctr_t CTR_RESET = 2'd2;

  // operation codes of an input item
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // table clearing sequencer states
  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } clr_state_t;

  // counter value of 2 or more predicts taken
  function automatic logic ctr_taken(input ctr_t ctr);
    ctr_taken = ctr[1];
  endfunction

  // one step toward the actual outcome, saturating at both ends
  function automatic ctr_t ctr_next(input ctr_t ctr, input logic taken);
    ctr_next = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) ctr_next = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) ctr_next = ctr - 2'd1;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/gbp_ram.sv */
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module gbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/gbp_clear.sv */
// post-reset clearing sequencer: writes the reset counter value to every entry
// depends on gbp_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module gbp_clear #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  output logic                          busy,
  output logic                          wr_en,
  output logic      [$clog2(DEPTH)-1:0] wr_addr
);

  import gbp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  clr_state_t     state_r, state_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CLR_SWEEP: if (addr_r == LAST_ADDR) state_nxt = CLR_DONE;
      CLR_DONE:  state_nxt = CLR_DONE;
      default:   state_nxt = CLR_DONE;
    endcase
  end

  // sweep address
  always_comb begin
    addr_nxt = addr_r;
    if (state_r == CLR_SWEEP) addr_nxt = addr_r + AW'(1);
  end

  // outputs
  always_comb begin
    busy  = 1'b0;
    wr_en = 1'b0;
    unique case (state_r)
      CLR_SWEEP: begin
        busy  = 1'b1;
        wr_en = 1'b1;
      end
      CLR_DONE:  busy = 1'b0;
      default:   busy = 1'b0;
    endcase
  end

  assign wr_addr = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CLR_SWEEP;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // once finished the sweep never restarts without reset
  `ASSERT_CLK(a_clr_stays_done, clk, rst_n, !busy |=> !busy, "clear restarted")
  // sweep walks the entries one per cycle
  `ASSERT_CLK(a_clr_step, clk, rst_n, busy && $past(busy) && $past(rst_n) |-> addr_r == $past(addr_r) + AW'(1), "clear skipped an entry")
  // the last entry is written right before the sweep ends
  `ASSERT_CLK(a_clr_last, clk, rst_n, $fell(busy) |-> $past(addr_r) == LAST_ADDR, "clear ended early")

endmodule

`default_nettype wire

/* rtl/gshare_branch_predictor.sv */
// gshare branch direction predictor, top level
// depends on gbp_pkg, gbp_ram, gbp_clear and assert_macros.svh
//
// usage:
//   input channel in_*: one item per handshake, in_operation selects predict
//   or update, in_branch_address is the byte address of the branch, and
//   in_outcome_taken is the resolved direction (used on update only).
//   result channel out_*: exactly one item per input item, in order,
//   out_predict_taken from the counter before any update.
//   an accepted item passes the stage 1 register, then the output register.
//   throughput: one item per cycle while out_ready is high, set by the single
//   read port and single write port of the counter memory; a read-modify-write
//   of the entry the next item reads is bypassed, so back-to-back updates never wait.
//   the history register is updated when an update item is accepted.
//   reset: the history clears at once; a clearing pass then writes every
//   counter to weakly taken, with in_ready low for the whole pass.
//   stall: the output register plus one in-flight item hold results while
//   out_ready is low; in_ready drops once both are full.
`default_nettype none

`include "assert_macros.svh"

module gshare_branch_predictor #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_branch_address,
  input  wire logic        in_outcome_taken,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_predict_taken
);

  import gbp_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int HB = $clog2(TABLE_ENTRIES + 1) - 1;
  localparam logic [IW-1:0] TBL_MASK = IW'(TABLE_ENTRIES - 1);

  logic [HB-1:0] ghist_r;

  logic          in_fire;
  logic [IW-1:0] rd_idx;

  logic          s1_valid_r;
  logic          s1_op_r;
  logic          s1_taken_r;
  logic [IW-1:0] s1_idx_r;
  logic          s1_byp_r;
  ctr_t          s1_byp_ctr_r;
  logic          s1_adv;
  logic          s1_wr;
  ctr_t          s1_ctr;
  ctr_t          s1_new;
  logic          byp_nxt;

  logic          out_valid_r;
  logic          out_taken_r;

  logic          clr_busy;
  logic          clr_we;
  logic [IW-1:0] clr_addr;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  ctr_t          ram_wdata;
  ctr_t          ram_rdata;

  // clearing sequencer
  gbp_clear #(
    .DEPTH (TABLE_ENTRIES)
  ) u_clear (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (clr_busy),
    .wr_en   (clr_we),
    .wr_addr (clr_addr)
  );

  // counter table
  gbp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // handshake and stage advance
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy && (!s1_valid_r || s1_adv);
  assign in_fire  = in_valid && in_ready;

  // index hash: word address xor history, masked to the table
  assign rd_idx = (in_branch_address[IW+1:2] ^ IW'(ghist_r)) & TBL_MASK;

  // counter modify in stage 1, with bypass of a same-cycle write
  assign s1_ctr  = s1_byp_r ? s1_byp_ctr_r : ram_rdata;
  assign s1_new  = ctr_next(s1_ctr, s1_taken_r);
  assign s1_wr   = s1_adv && (s1_op_r == OP_UPDATE);
  assign byp_nxt = s1_wr && (s1_idx_r == rd_idx);

  // memory write port shared by clear pass and updates
  assign ram_we    = clr_we || s1_wr;
  assign ram_waddr = clr_busy ? clr_addr : s1_idx_r;
  assign ram_wdata = clr_busy ? CTR_RESET : s1_new;

  // global history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ghist_r <= '0;
    end else if (in_fire && (in_operation == OP_UPDATE)) begin
      ghist_r <= HB'({ghist_r, in_outcome_taken});
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= in_operation;
      s1_taken_r   <= in_outcome_taken;
      s1_idx_r     <= rd_idx;
      s1_byp_r     <= byp_nxt;
      s1_byp_ctr_r <= s1_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_taken_r <= ctr_taken(s1_ctr);
  end

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_taken_r;

  // no item enters while the table is being cleared
  `ASSERT_CLK(a_no_item_in_clear, clk, rst_n,
    clr_busy |-> !s1_valid_r && !s1_wr, "item during clear")
  // history moves only on an accepted update
  `ASSERT_CLK(a_hist_stable, clk, rst_n,
    !(in_fire && in_operation == OP_UPDATE) |=> $stable(ghist_r),
    "history changed without update")
  // a stalled stage 1 item keeps its index and bypass data
  `ASSERT_CLK(a_s1_hold, clk, rst_n,
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_idx_r) && $stable(s1_byp_r),
    "stage 1 lost its item")
  // bypass is only taken when the previous cycle wrote the entry just read
  `ASSERT_CLK(a_byp_src, clk, rst_n,
    $past(in_fire) && s1_byp_r |-> $past(s1_wr) && $past(s1_idx_r) == s1_idx_r,
    "bad bypass")

endmodule

`default_nettype wire

/* dv/gshare_branch_predictor_tb.sv */
// self-checking testbench for the gshare branch predictor
// depends on gbp_pkg and the gshare_branch_predictor rtl; a scoreboard
// class mirrors the counter table and history and checks every prediction
`default_nettype none

module gshare_branch_predictor_tb;
  import gbp_pkg::*;

  localparam int TABLE_ENTRIES = 1024;
  localparam int HIST_W        = $clog2(TABLE_ENTRIES);
  localparam int RANDOM_ITEMS  = 1700;
  localparam int HOLD_CYCLES   = 150;
  localparam int POOL_SIZE     = 24;
  localparam int REPORT_LIMIT  = 10;
  localparam ctr_t TAKEN_THRESHOLD = 2'd2;

  // mirror of the counter table and global history, plus pending predictions
  class gshare_mirror;
    ctr_t              ctr_table[TABLE_ENTRIES];
    logic [HIST_W-1:0] ghist;
    logic              predicted_dirs[$];
    int                errors;
    int                noted;

    function new();
      foreach (ctr_table[i]) ctr_table[i] = CTR_RESET;
      ghist  = '0;
      errors = 0;
      noted  = 0;
    endfunction

    function void report(string msg);
      if (errors < REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endfunction

    // accepted input item: record its prediction, then train on update
    function void note_lookup(logic op, logic [31:0] addr, logic taken);
      logic [HIST_W-1:0] idx;
      ctr_t              ctr;
      idx = addr[HIST_W+1:2] ^ ghist;
      ctr = ctr_table[idx];
      predicted_dirs.push_back(ctr >= TAKEN_THRESHOLD);
      noted++;
      if (op == OP_UPDATE) begin
        if (taken && ctr != CTR_MAX) ctr = ctr + 2'd1;
        else if (!taken && ctr != CTR_MIN) ctr = ctr - 2'd1;
        ctr_table[idx] = ctr;
        ghist = {ghist[HIST_W-2:0], taken};
      end
    endfunction

    // accepted result item: compare with the oldest pending prediction
    function void check_prediction(logic got);
      logic want;
      if (predicted_dirs.size() == 0) begin
        report($sformatf("result %0b with nothing pending", got));
      end else begin
        want = predicted_dirs.pop_front();
        if (got !== want)
          report($sformatf("predict_taken expected %0b actual %0b", want, got));
      end
    endfunction

    function int pending();
      return predicted_dirs.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_branch_address;
  logic        in_outcome_taken;
  logic        out_valid;
  logic        out_ready;
  logic        out_predict_taken;

  gshare_mirror mirror;
  int           items_sent;
  int           burst_left;
  bit           no_gaps;
  bit           long_hold_req;
  logic [31:0]  branch_pool[POOL_SIZE];

  gshare_branch_predictor #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_branch_address(in_branch_address),
    .in_outcome_taken (in_outcome_taken),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_predict_taken(out_predict_taken)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // handshake monitor feeding the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        mirror.note_lookup(in_operation, in_branch_address, in_outcome_taken);
      if (out_valid && out_ready)
        mirror.check_prediction(out_predict_taken);
    end
  end

  // offer one item in bursts with random gaps, wait until accepted
  task automatic send_item(input logic op, input logic [31:0] addr, input logic taken);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_branch_address <= addr;
    in_outcome_taken  <= taken;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // sender pause until every sent item is noted and its prediction is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (mirror.noted != items_sent || mirror.pending() != 0) @(posedge clk);
  endtask

  // receiver: stall patterns of its own, plus a long hold-off on request
  initial begin
    int mode;
    int span;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        long_hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 40);
        for (int k = 0; k < span; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] hot_addr;
    logic [31:0] addr;
    int          trips;
    int          runs;
    mirror            = new();
    items_sent        = 0;
    burst_left        = 0;
    no_gaps           = 1'b0;
    long_hold_req     = 1'b0;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_operation      <= OP_PREDICT;
    in_branch_address <= '0;
    in_outcome_taken  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: address extremes, outcome ignored on predict
    send_item(OP_PREDICT, 32'h0000_0000, 1'b1);
    send_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b0);
    // taken run saturates the history at all ones and the counter at max
    for (int i = 0; i < 12; i++) send_item(OP_UPDATE, 32'h0000_1000, 1'b1);
    // low byte bits and high address bits do not reach the index
    send_item(OP_PREDICT, 32'h0000_1003, 1'b0);
    send_item(OP_PREDICT, 32'hFFFF_1000, 1'b1);
    // not-taken run walks counters down
    for (int i = 0; i < 8; i++) send_item(OP_UPDATE, 32'h0000_1000, 1'b0);
    send_item(OP_UPDATE, 32'hFFFF_FFFC, 1'b1);
    wait_drained();

    // block fills up while the receiver holds off
    long_hold_req = 1'b1;
    no_gaps = 1'b1;
    for (int i = 0; i < 60; i++)
      send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
    no_gaps = 1'b0;
    wait_drained();

    // a working set of branches, some with stray low bits
    foreach (branch_pool[i]) branch_pool[i] = $urandom;

    // random: mostly loop-like branch streams, the rest noise
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        hot_addr = branch_pool[$urandom_range(0, POOL_SIZE - 1)];
        trips = $urandom_range(1, 12);
        for (int t = 0; t < trips; t++) begin
          if ($urandom_range(0, 1))
            send_item(OP_PREDICT, hot_addr, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 3) == 0) begin
            addr = branch_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_item(OP_UPDATE, addr, 1'($urandom_range(0, 1)));
          end
          send_item(OP_UPDATE, hot_addr, 1'b1);
        end
        // loop exit
        send_item(OP_UPDATE, hot_addr, 1'b0);
      end else begin
        runs = $urandom_range(1, 8);
        for (int r = 0; r < runs; r++)
          send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
      end
      if (items_sent > RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 20)
        wait_drained();
    end

    // drain and let the pipeline settle
    wait_drained();
    repeat (10) @(posedge clk);
    if (mirror.pending() != 0) mirror.report("predictions left over at the end");
    if (mirror.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/gbp_pkg.sv
rtl/gbp_ram.sv
rtl/gbp_clear.sv
rtl/gshare_branch_predictor.sv
dv/gshare_branch_predictor_tb.sv
